// ----- sv/sc_pkg.sv -----
// Package for the step counter: payload structs, configuration struct,
// register indexes and constants. Used by sc_regs, sc_isqrt and step_counter.
package sc_pkg;

  // Default number of fraction bits of the Q format.
  localparam int FRACTION_BITS = 8;

  // Configuration port geometry.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Register indexes in the configuration map.
  localparam logic [1:0] REG_THRESHOLD_HIGH = 2'd0;
  localparam logic [1:0] REG_THRESHOLD_LOW  = 2'd1;
  localparam logic [1:0] REG_FILTER_ALPHA   = 2'd2;
  localparam logic [1:0] REG_SAVE_INTERVAL  = 2'd3;

  // Register reset values and the filter full scale, which do not depend on the Q format.
  localparam logic [8:0]  ALPHA_RESET    = 9'd77;
  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [8:0]  ALPHA_FULL     = 9'd256;

  // Square root of a 32-bit value takes one step per result bit.
  localparam int SQRT_STEPS = 16;
  localparam int SQRT_CW    = $clog2(SQRT_STEPS);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               motion_valid;
  } in_item_t;

  typedef struct packed {
    logic [31:0] total_steps;
    logic        step_seen;
    logic        save_request;
    logic [15:0] smoothed_magnitude;
  } out_item_t;

  typedef struct packed {
    logic [15:0] threshold_high;
    logic [15:0] threshold_low;
    logic [8:0]  filter_alpha;
    logic [15:0] save_interval;
  } cfg_t;

endpackage

// ----- sv/sc_regs.sv -----
// Configuration register file of the step counter behind an APB-style port.
// Depends on sc_pkg for the register indexes and the configuration struct.
module sc_regs #(
  parameter int FracBits = sc_pkg::FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sc_pkg::APB_AW-1:0] paddr,
  input  logic [sc_pkg::APB_DW-1:0] pwdata,
  output logic [sc_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output sc_pkg::cfg_t              cfg_o
);
  import sc_pkg::*;

  localparam logic [15:0] HighReset = 16'(32'd14 << FracBits);
  localparam logic [15:0] LowReset  = 16'(32'd8 << FracBits);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_high <= HighReset;
      cfg_q.threshold_low  <= LowReset;
      cfg_q.filter_alpha   <= ALPHA_RESET;
      cfg_q.save_interval  <= INTERVAL_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD_HIGH: cfg_q.threshold_high <= pwdata[15:0];
        REG_THRESHOLD_LOW:  cfg_q.threshold_low  <= pwdata[15:0];
        REG_FILTER_ALPHA:   cfg_q.filter_alpha   <= pwdata[8:0];
        REG_SAVE_INTERVAL:  cfg_q.save_interval  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD_HIGH: prdata = {16'd0, cfg_q.threshold_high};
      REG_THRESHOLD_LOW:  prdata = {16'd0, cfg_q.threshold_low};
      REG_FILTER_ALPHA:   prdata = {23'd0, cfg_q.filter_alpha};
      REG_SAVE_INTERVAL:  prdata = {16'd0, cfg_q.save_interval};
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/sc_mul.sv -----
// Shared 16x16 unsigned multiplier of the step counter with a registered product.
// It serves the three squares and both filter weights in turn; no package use.
module sc_mul (
  input  logic        clk_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- sv/sc_isqrt.sv -----
// Iterative floor square root of a 32-bit value, one result bit per cycle.
// Depends on sc_pkg for the step count.
module sc_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [15:0] root_o
);
  import sc_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [SQRT_CW-1:0] cnt_q;
  logic [31:0]        rem_q, rem_d;
  logic [31:0]        root_q, root_d;
  logic [31:0]        bit_w;
  logic [31:0]        trial;

  assign bit_w = 32'd1 << {cnt_q, 1'b0};
  assign trial = root_q + bit_w;

  always_comb begin
    if (rem_q >= trial) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + bit_w;
    end else begin
      rem_d  = rem_q;
      root_d = root_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CW'(SQRT_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= value_i;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[15:0];

  ap_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && !done_q)
    else $error("square root did not start");

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("square root done while busy");

  ap_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == '0 && !start_i |=> done_q)
    else $error("square root missed its done pulse");

endmodule

// ----- sv/step_counter.sv -----
// Top level of the step counter: sequencer, state registers and output register.
// Depends on sc_pkg, sc_regs, sc_mul and sc_isqrt.
//
// Usage. One three-axis acceleration sample enters on the input channel
// (in_valid_i, in_stall_o, in_data_i); one result leaves on the output channel
// (out_valid_o, out_stall_i, out_data_o) for every sample, in order. A
// transaction completes at a rising edge with valid high and stall low.
// Thresholds, filter weight and save interval are written over the APB-style
// port while no sample is in flight; pready is always high.
// Steps: a sample with motion_valid set passes SQX, SQY, SQZ and SQS, which
// form the three squares and their sum on the shared multiplier; it then waits
// in ROOT while the square-root unit iterates and hands over its done pulse,
// and the filter and detector take FA, FB, FC and DONE. A sample without
// motion_valid goes from IDLE straight to DONE. The next sample is
// taken in the cycle after the previous one reaches the output register.
// Reset clears the filter level, the armed flag and both step counts, and
// loads the register defaults. When the receiver stalls, a finished result is
// held in the output register while the next sample is already accepted and
// worked on; that sample waits in its last step until the register is free.
module step_counter #(
  parameter int FracBits = sc_pkg::FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sc_pkg::in_item_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sc_pkg::out_item_t         out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sc_pkg::APB_AW-1:0] paddr,
  input  logic [sc_pkg::APB_DW-1:0] pwdata,
  output logic [sc_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import sc_pkg::*;

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQX  = 4'd1;
  localparam logic [3:0] ST_SQY  = 4'd2;
  localparam logic [3:0] ST_SQZ  = 4'd3;
  localparam logic [3:0] ST_SQS  = 4'd4;
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_FA   = 4'd6;
  localparam logic [3:0] ST_FB   = 4'd7;
  localparam logic [3:0] ST_FC   = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  cfg_t        cfg;
  logic [3:0]  state_q, state_d;
  logic        in_acc;
  logic        out_free;

  // Magnitudes of the sample, captured when it is accepted.
  logic [15:0] ax_q, ay_q, az_q;

  // Working registers.
  logic [31:0] sum_q;
  logic [23:0] acc_q;

  // Block state.
  logic [15:0] filt_q;
  logic        armed_q;
  logic [31:0] steps_q;
  logic [31:0] saved_q;
  logic        seen_q;
  logic        save_q;

  // Output register.
  logic        out_valid_q;
  out_item_t   out_q;

  // Shared multiplier and square-root unit.
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic        root_start;
  logic        root_done;
  logic [15:0] root;
  logic [31:0] root_arg;

  // Filter and detector.
  logic [8:0]  alpha_sat;
  logic [8:0]  alpha_rest;
  logic [24:0] acc_sum;
  logic [15:0] filt_new;
  logic [31:0] steps_inc;
  logic [31:0] since_save;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  sc_regs #(
    .FracBits(FracBits)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  sc_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  sc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .value_i(root_arg),
    .done_o (root_done),
    .root_o (root)
  );

  // Handshakes. A sample is taken only when the sequencer is idle; the result
  // register frees itself when the receiver takes its transaction.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Weights of the low-pass filter; a weight above full scale acts as full scale.
  assign alpha_sat  = (cfg.filter_alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.filter_alpha;
  assign alpha_rest = ALPHA_FULL - alpha_sat;

  // The multiplier sees one operand pair per step; its product is registered and appears in the following cycle.
  always_comb begin
    case (state_q)
      ST_SQX: begin
        mul_a = ax_q;
        mul_b = ax_q;
      end
      ST_SQY: begin
        mul_a = ay_q;
        mul_b = ay_q;
      end
      ST_SQZ: begin
        mul_a = az_q;
        mul_b = az_q;
      end
      ST_FA: begin
        mul_a = {7'd0, alpha_sat};
        mul_b = root;
      end
      ST_FB: begin
        mul_a = {7'd0, alpha_rest};
        mul_b = filt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The last square joins the sum on its way into the root unit. Three squares
  // of at most 2^30 each cannot overflow 32 bits.
  assign root_start = (state_q == ST_SQS);
  assign root_arg   = sum_q + mul_p;

  // In the last filter step the product holds the old-level term.
  assign acc_sum    = {1'b0, acc_q} + {1'b0, mul_p[23:0]};
  assign filt_new   = acc_sum[23:8];
  assign steps_inc  = steps_q + 32'd1;
  assign since_save = steps_inc - saved_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = in_data_i.motion_valid ? ST_SQX : ST_DONE;
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQZ;
      ST_SQZ:  state_d = ST_SQS;
      ST_SQS:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_FA;
        end
      end
      ST_FA:   state_d = ST_FB;
      ST_FB:   state_d = ST_FC;
      ST_FC:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q <= abs16(in_data_i.accel_x);
      ay_q <= abs16(in_data_i.accel_y);
      az_q <= abs16(in_data_i.accel_z);
    end
    case (state_q)
      ST_SQY:  sum_q <= mul_p;
      ST_SQZ:  sum_q <= sum_q + mul_p;
      ST_FB:   acc_q <= mul_p[23:0];
      default: ;
    endcase
  end

  // Filter level, detector and step counts. Only a valid sample reaches the last
  // filter step; an invalid one only clears the step-seen and save flags on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      armed_q <= 1'b0;
      steps_q <= '0;
      saved_q <= '0;
      seen_q  <= 1'b0;
      save_q  <= 1'b0;
    end else if (in_acc) begin
      seen_q <= 1'b0;
      save_q <= 1'b0;
    end else if (state_q == ST_FC) begin
      filt_q <= filt_new;
      if (!armed_q && filt_new > cfg.threshold_high) begin
        armed_q <= 1'b1;
      end else if (armed_q && filt_new < cfg.threshold_low) begin
        // Falling through the low threshold completes one step.
        armed_q <= 1'b0;
        steps_q <= steps_inc;
        seen_q  <= 1'b1;
        if (since_save >= {16'd0, cfg.save_interval}) begin
          save_q  <= 1'b1;
          saved_q <= steps_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.total_steps        <= steps_q;
      out_q.step_seen          <= seen_q;
      out_q.save_request       <= save_q;
      out_q.smoothed_magnitude <= filt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  ap_save_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.save_request || out_data_o.step_seen))
    else $error("save request without a completed step");

  ap_step_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (steps_q == $past(steps_q) || steps_q == $past(steps_q) + 32'd1))
    else $error("step count moved by more than one");

  ap_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && !root_done) |=> state_q == ST_ROOT)
    else $error("sequencer left the root step early");

  ap_count_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FC) |=> (steps_q == $past(steps_q) && armed_q == $past(armed_q)))
    else $error("detector state changed outside the filter step");

endmodule
